// ===== rtl/adec_pkg.sv =====
// Shared types and constants for the averaging decimator.
`default_nettype none
package adec_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CHAN_W    = 3;
  localparam int SUM_W     = 18;
  localparam int RATE_W    = 20;
  localparam int COUNT_W   = 4;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [1:0] REG_INPUT_RATE    = 2'd0;
  localparam logic [1:0] REG_OUTPUT_RATE   = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [RATE_W-1:0]  INPUT_RATE_RESET    = 20'd48000;
  localparam logic [RATE_W-1:0]  OUTPUT_RATE_RESET   = 20'd48000;
  localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
    logic                       last;
    logic                       produce;
    logic                       write;
    logic                       load;
    logic                       shift2;
    logic                       pass;
  } stage_t;

endpackage
`default_nettype wire

// ===== rtl/adec_in_if.sv =====
// Input channel: one signed PCM sample per item.
`default_nettype none
interface adec_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [adec_pkg::SAMPLE_W-1:0] sample_in;
  logic                                 buffer_end;

  modport source(output valid, sample_in, buffer_end, input ready);
  modport sink(input valid, sample_in, buffer_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/adec_out_if.sv =====
// Output channel: one averaged or passed-through sample per item.
`default_nettype none
interface adec_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [adec_pkg::SAMPLE_W-1:0] sample_out;
  logic [adec_pkg::CHAN_W-1:0]          channel_out;
  logic                                 last_out;

  modport source(output valid, sample_out, channel_out, last_out, input ready);
  modport sink(input valid, sample_out, channel_out, last_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/adec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module adec_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [AW-1:0]            raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/averaging_decimator_2x_4x.sv =====
// Boxcar averaging decimator for interleaved 16-bit PCM, 2x or 4x.
//
// Usage:
//   sample_ch takes one sample per item, channels interleaved in order;
//   buffer_end marks the last sample of a buffer and drops a partial group.
//   result_ch gives one item per pass-through sample, or one per channel
//   at the final frame of a 2- or 4-frame group (sum shifted right, floor).
//   The APB port sets input_rate (0x0), output_rate (0x4), channel_count
//   (0x8); write it only while the stream is idle.
// Timing:
//   One item per cycle sustained while sample_ch.ready holds high. An
//   accepted item's sum RAM read lands in the s1 stage, and its result
//   is then held in the output queue. Back-to-back items on the same
//   channel forward the pending sum around the RAM write.
// Reset:
//   Registers return to 48000, 48000 and 2; position, phase and sum valid
//   bits clear, so no sum RAM clearing pass is needed.
// Stall:
//   A 4-entry output queue absorbs results; sample_ch.ready drops only when
//   the queue plus the result in flight would overflow it.
`default_nettype none
module averaging_decimator_2x_4x #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [adec_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [adec_pkg::DATA_W-1:0]   pwdata,
  output      logic [adec_pkg::DATA_W-1:0]   prdata,
  output      logic                          pready,
  adec_in_if.sink                            sample_ch,
  adec_out_if.source                         result_ch
);
  localparam int IDX_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;
  localparam int Q_CW     = 3;
  localparam logic [5:0] MAX_CH = 6'(MAX_CHANNELS);

  logic [adec_pkg::RATE_W-1:0]  input_rate;
  logic [adec_pkg::RATE_W-1:0]  output_rate;
  logic [adec_pkg::COUNT_W-1:0] channel_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_rate    <= adec_pkg::INPUT_RATE_RESET;
      output_rate   <= adec_pkg::OUTPUT_RATE_RESET;
      channel_count <= adec_pkg::CHANNEL_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        adec_pkg::REG_INPUT_RATE:    input_rate    <= pwdata[adec_pkg::RATE_W-1:0];
        adec_pkg::REG_OUTPUT_RATE:   output_rate   <= pwdata[adec_pkg::RATE_W-1:0];
        adec_pkg::REG_CHANNEL_COUNT: channel_count <= pwdata[adec_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      adec_pkg::REG_INPUT_RATE:    prdata = 32'(input_rate);
      adec_pkg::REG_OUTPUT_RATE:   prdata = 32'(output_rate);
      adec_pkg::REG_CHANNEL_COUNT: prdata = 32'(channel_count);
      default:                     prdata = '0;
    endcase
  end

  // mode and channel count
  logic       mode_2x;
  logic       mode_4x;
  logic [5:0] chans;

  always_comb begin
    mode_2x = (output_rate != '0) && ({1'b0, input_rate} == {output_rate, 1'b0});
    mode_4x = (output_rate != '0) && ({2'b0, input_rate} == {output_rate, 2'b0});
    if (channel_count == '0) begin
      chans = 6'd1;
    end else if ({2'b0, channel_count} > MAX_CH) begin
      chans = MAX_CH;
    end else begin
      chans = {2'b0, channel_count};
    end
  end

  // stream state
  logic [2:0]              pos;
  logic [1:0]              phase;
  logic [MAX_CHANNELS-1:0] sum_valid;
  logic [2:0]              pos_next;
  logic [1:0]              phase_next;
  logic [MAX_CHANNELS-1:0] sum_valid_next;

  logic [Q_CW-1:0] q_count;
  logic            s1_valid;
  adec_pkg::stage_t s1;
  logic [IDX_W-1:0] s1_slot;

  logic             accept;
  logic [IDX_W-1:0] slot;
  logic             wrap;
  logic             final_frame;
  adec_pkg::stage_t s0;

  assign slot = IDX_W'(pos);
  assign sample_ch.ready = (q_count + Q_CW'(s1_valid && s1.produce)) < Q_CW'(Q_DEPTH);
  assign accept = sample_ch.valid && sample_ch.ready;

  always_comb begin
    wrap           = ({3'b0, pos} + 6'd1) >= chans;
    final_frame    = mode_4x ? (phase == 2'd3) : (phase != 2'd0);
    pos_next       = pos;
    phase_next     = phase;
    sum_valid_next = sum_valid;
    s0.sample      = sample_ch.sample_in;
    s0.channel     = pos;
    s0.pass        = !(mode_2x || mode_4x);
    s0.shift2      = mode_4x;
    s0.load        = (phase == 2'd0) || !sum_valid[slot];
    s0.write       = !s0.pass;
    s0.produce     = s0.pass || final_frame;
    s0.last        = s0.pass ? sample_ch.buffer_end : (sample_ch.buffer_end && wrap);
    if (accept) begin
      if (s0.pass) begin
        phase_next = 2'd0;
        pos_next   = (sample_ch.buffer_end || wrap) ? 3'd0 : pos + 3'd1;
      end else if (sample_ch.buffer_end) begin
        pos_next       = 3'd0;
        phase_next     = 2'd0;
        sum_valid_next = '0;
      end else begin
        sum_valid_next[slot] = 1'b1;
        if (wrap) begin
          pos_next   = 3'd0;
          phase_next = final_frame ? 2'd0 : phase + 2'd1;
        end else begin
          pos_next = pos + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      phase     <= '0;
      sum_valid <= '0;
    end else begin
      pos       <= pos_next;
      phase     <= phase_next;
      sum_valid <= sum_valid_next;
    end
  end

  // sum RAM, read at accept, written back from s1 in the next cycle
  logic [adec_pkg::SUM_W-1:0]        ram_rdata;
  logic signed [adec_pkg::SUM_W-1:0] s1_base;
  logic signed [adec_pkg::SUM_W-1:0] s1_sum;
  logic                              fwd;
  logic signed [adec_pkg::SUM_W-1:0] fwd_data;

  adec_ram #(
    .WIDTH(adec_pkg::SUM_W),
    .DEPTH(MAX_CHANNELS)
  ) u_sums (
    .clk  (clk),
    .we   (s1_valid && s1.write),
    .waddr(s1_slot),
    .wdata(s1_sum),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (s1.load) begin
      s1_base = '0;
    end else if (fwd) begin
      s1_base = fwd_data;
    end else begin
      s1_base = $signed(ram_rdata);
    end
    s1_sum = s1_base + {{(adec_pkg::SUM_W-adec_pkg::SAMPLE_W){s1.sample[15]}}, s1.sample};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= s0;
      s1_slot  <= slot;
      fwd      <= s1_valid && s1.write && (s1_slot == slot);
      fwd_data <= s1_sum;
    end
  end

  // output queue
  adec_pkg::out_item_t q_mem [Q_DEPTH];
  adec_pkg::out_item_t q_in;
  logic [Q_AW-1:0]     q_wr;
  logic [Q_AW-1:0]     q_rd;
  logic                push;
  logic                pop;

  assign push = s1_valid && s1.produce;
  assign pop  = result_ch.valid && result_ch.ready;

  always_comb begin
    q_in.channel = s1.channel;
    q_in.last    = s1.last;
    if (s1.pass) begin
      q_in.sample = s1.sample;
    end else if (s1.shift2) begin
      q_in.sample = s1_sum[17:2];
    end else begin
      q_in.sample = s1_sum[16:1];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr] <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        q_wr <= q_wr + Q_AW'(1);
      end
      if (pop) begin
        q_rd <= q_rd + Q_AW'(1);
      end
      q_count <= q_count + Q_CW'(push) - Q_CW'(pop);
    end
  end

  assign result_ch.valid       = q_count != '0;
  assign result_ch.sample_out  = q_mem[q_rd].sample;
  assign result_ch.channel_out = q_mem[q_rd].channel;
  assign result_ch.last_out    = q_mem[q_rd].last;
endmodule
`default_nettype wire
